// File: rtl/tcbuf_pkg.sv
// Shared types and constants for the text cell buffer.
package tcbuf_pkg;

	// Command codes carried in func
	localparam logic [3:0] FN_MOVE    = 4'd0;
	localparam logic [3:0] FN_PUT     = 4'd1;
	localparam logic [3:0] FN_FWD     = 4'd2;
	localparam logic [3:0] FN_DOWN    = 4'd3;
	localparam logic [3:0] FN_HLINE   = 4'd4;
	localparam logic [3:0] FN_VLINE   = 4'd5;
	localparam logic [3:0] FN_READ    = 4'd6;
	localparam logic [3:0] FN_CLEAR   = 4'd7;
	localparam logic [3:0] FN_PUT_ADV = 4'd8;

	// Result status codes
	localparam logic [2:0] STS_OK    = 3'd0;
	localparam logic [2:0] STS_RANGE = 3'd1;
	localparam logic [2:0] STS_BELL  = 3'd2;
	localparam logic [2:0] STS_NULL  = 3'd3;
	localparam logic [2:0] STS_TRUNC = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_FILL = 2'd2;

	// Cursor index: at most 64 x 64 cells in use
	localparam int IDX_W = 13;

	// Fill character after reset
	localparam logic [7:0] RESET_FILL = 8'd35;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Effective screen geometry
	typedef struct packed {
		logic [6:0]       eff_rows;
		logic [6:0]       eff_cols;
		logic [IDX_W-1:0] total;
	} geom_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic [3:0]       func;
		logic             ok;
		logic [IDX_W-1:0] idx;
		logic [6:0]       row;
		logic [6:0]       col;
		logic [7:0]       len;
		logic [7:0]       ch;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_char;
		logic [6:0] cursor_row;
		logic [6:0] cursor_col;
	} res_t;

endpackage

// File: rtl/tcbuf_ram.sv
// Generic simple dual-port RAM with registered read.
module tcbuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/tcbuf_geom.sv
// Configuration registers and effective screen geometry.
module tcbuf_geom #(
	parameter int MAX_CELLS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output tcbuf_pkg::geom_t     geom,
	output logic                 busy,
	output logic                 home,
	output logic [7:0]           fill
);

	logic [6:0] rows_q;
	logic [6:0] cols_q;
	logic [7:0] fill_q;
	logic [1:0] busy_q;
	logic [6:0] eff_rows_q;
	logic [6:0] eff_cols_q;
	logic [tcbuf_pkg::IDX_W-1:0] total_q;

	logic [6:0]  rc;
	logic [6:0]  cc;
	logic [6:0]  cc_m1;
	logic [13:0] prod;
	logic        over;
	logic [6:0]  rsel;
	logic [13:0] tot_prod;
	logic [6:0]  quot [64];

	// Rows that fit for each column count, capped at 64
	for (genvar g = 0; g < 64; g++) begin : g_quot
		localparam int QV = (MAX_CELLS / (g + 1) > 64) ? 64 : MAX_CELLS / (g + 1);
		assign quot[g] = 7'(QV);
	end

	// Clamp and fit the geometry
	always_comb begin
		rc = (rows_q == 7'd0) ? 7'd1 : ((rows_q > 7'd64) ? 7'd64 : rows_q);
		cc = (cols_q == 7'd0) ? 7'd1 : ((cols_q > 7'd64) ? 7'd64 : cols_q);
		cc_m1 = cc - 7'd1;
		prod = {7'd0, rc} * {7'd0, cc};
		over = {18'd0, prod} > 32'(MAX_CELLS);
		rsel = over ? quot[cc_m1[5:0]] : rc;
		tot_prod = {7'd0, eff_rows_q} * {7'd0, eff_cols_q};
	end

	// Config writes; busy stays high while the registered geometry settles after a write or reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= 7'd8;
			cols_q     <= 7'd40;
			fill_q     <= tcbuf_pkg::RESET_FILL;
			busy_q     <= 2'd2;
			eff_rows_q <= 7'd1;
			eff_cols_q <= 7'd1;
			total_q    <= tcbuf_pkg::IDX_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tcbuf_pkg::CFG_ROWS: rows_q <= cfg_data[6:0];
					tcbuf_pkg::CFG_COLS: cols_q <= cfg_data[6:0];
					tcbuf_pkg::CFG_FILL: fill_q <= cfg_data;
					default: ;
				endcase
				busy_q <= 2'd2;
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
			eff_rows_q <= rsel;
			eff_cols_q <= cc;
			total_q    <= tot_prod[tcbuf_pkg::IDX_W-1:0];
		end
	end

	assign geom.eff_rows = eff_rows_q;
	assign geom.eff_cols = eff_cols_q;
	assign geom.total    = total_q;
	assign busy = busy_q != 2'd0;
	assign home = cfg_we && (cfg_index == tcbuf_pkg::CFG_ROWS ||
		cfg_index == tcbuf_pkg::CFG_COLS);
	assign fill = fill_q;

endmodule

// File: rtl/tcbuf_front.sv
// Front end: takes input beats, range-checks and maps the target cell.
module tcbuf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [3:0]       func,
	input  logic [6:0]       row,
	input  logic [6:0]       col,
	input  logic [7:0]       length,
	input  logic [7:0]       ch,
	input  tcbuf_pkg::geom_t geom,
	input  logic             hold,
	input  logic             q_full,
	output logic             push,
	output tcbuf_pkg::cmd_t  cmd
);

	logic       v_s1;
	logic [3:0] func_s1;
	logic [6:0] row_s1;
	logic [6:0] col_s1;
	logic [7:0] len_s1;
	logic [7:0] ch_s1;

	logic        accept;
	logic [6:0]  row_m1;
	logic [6:0]  col_m1;
	logic [13:0] row_off;

	assign in_stall = hold | (v_s1 & q_full);
	assign accept   = in_valid & ~in_stall;
	assign push     = v_s1 & ~q_full;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			row_s1  <= row;
			col_s1  <= col;
			len_s1  <= length;
			ch_s1   <= ch;
		end
	end

	// Classify: range check and linear cell index
	always_comb begin
		row_m1  = row_s1 - 7'd1;
		col_m1  = col_s1 - 7'd1;
		row_off = {7'd0, row_m1} * {7'd0, geom.eff_cols};
		cmd.func = func_s1;
		cmd.ok   = (row_s1 != 7'd0) && (row_s1 <= geom.eff_rows) &&
			(col_s1 != 7'd0) && (col_s1 <= geom.eff_cols);
		cmd.idx  = row_off[tcbuf_pkg::IDX_W-1:0] +
			{{(tcbuf_pkg::IDX_W-7){1'b0}}, col_m1};
		cmd.row  = row_s1;
		cmd.col  = col_s1;
		cmd.len  = len_s1;
		cmd.ch   = ch_s1;
	end

endmodule

// File: rtl/tcbuf_fifo.sv
// Short command queue between front and back.
module tcbuf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcbuf_pkg::cmd_t din,
	input  logic            pop,
	output tcbuf_pkg::cmd_t dout,
	output logic            empty,
	output logic            full
);

	tcbuf_pkg::cmd_t                 mem_q [tcbuf_pkg::Q_DEPTH];
	logic [tcbuf_pkg::Q_AW-1:0]      wr_ptr_q;
	logic [tcbuf_pkg::Q_AW-1:0]      rd_ptr_q;
	logic [tcbuf_pkg::Q_AW:0]        cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == (tcbuf_pkg::Q_AW+1)'(tcbuf_pkg::Q_DEPTH);
	assign dout  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: rtl/tcbuf_back.sv
// Back end: executes commands on the cell memory, owns cursor and result.
module tcbuf_back #(
	parameter int MAX_CELLS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tcbuf_pkg::geom_t geom,
	input  logic             home,
	input  logic [7:0]       fill,
	input  tcbuf_pkg::cmd_t  cmd,
	input  logic             q_empty,
	output logic             pop,
	output logic             init_busy,
	output logic             out_valid,
	input  logic             out_stall,
	output tcbuf_pkg::res_t  res
);

	localparam int AW = $clog2(MAX_CELLS);
	localparam int IW = tcbuf_pkg::IDX_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LINE  = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [IW-1:0] cur_idx_q, cur_idx_d;
	logic [6:0]    cur_row_q, cur_row_d;
	logic [6:0]    cur_col_q, cur_col_d;
	logic [7:0]    line_cnt_q, line_cnt_d;
	logic [7:0]    line_ch_q, line_ch_d;
	logic          line_vert_q, line_vert_d;
	logic          bell_q, bell_d;
	logic          out_valid_q, out_valid_d;
	tcbuf_pkg::res_t res_q, res_d;

	logic          out_free;
	logic          ld;
	logic [2:0]    sts;
	logic [7:0]    rd;
	logic          bell_now;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	logic [IW:0]   fwd_sum;
	logic          fwd_wrap;
	logic [IW-1:0] fwd_idx;
	logic [6:0]    fwd_row;
	logic [6:0]    fwd_col;
	logic          dn_bell;
	logic [IW-1:0] dn_idx;
	logic          clr_last;

	tcbuf_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign out_free  = ~out_valid_q | ~out_stall;
	assign clr_last  = clr_q == LAST_ADDR;
	assign init_busy = state_q == S_INIT;

	// Cursor step forward (wraps home past the last cell) and step down
	always_comb begin
		fwd_sum  = {1'b0, cur_idx_q} + {{IW{1'b0}}, 1'b1};
		fwd_wrap = fwd_sum >= {1'b0, geom.total};
		fwd_idx  = fwd_wrap ? '0 : fwd_sum[IW-1:0];
		if (fwd_wrap) begin
			fwd_row = 7'd1;
			fwd_col = 7'd1;
		end else if (cur_col_q == geom.eff_cols) begin
			fwd_row = cur_row_q + 7'd1;
			fwd_col = 7'd1;
		end else begin
			fwd_row = cur_row_q;
			fwd_col = cur_col_q + 7'd1;
		end
		dn_bell = cur_row_q >= geom.eff_rows;
		dn_idx  = cur_idx_q + {{(IW-7){1'b0}}, geom.eff_cols};
	end

	// Command sequencer
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		cur_idx_d   = cur_idx_q;
		cur_row_d   = cur_row_q;
		cur_col_d   = cur_col_q;
		line_cnt_d  = line_cnt_q;
		line_ch_d   = line_ch_q;
		line_vert_d = line_vert_q;
		bell_d      = bell_q;
		pop         = 1'b0;
		ld          = 1'b0;
		sts         = tcbuf_pkg::STS_OK;
		rd          = 8'd0;
		bell_now    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = AW'(cur_idx_q);
		mem_wdata   = cmd.ch;
		mem_raddr   = AW'(cmd.idx);

		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = tcbuf_pkg::RESET_FILL;
				clr_d     = clr_q + 1'b1;
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					unique case (cmd.func) inside
						tcbuf_pkg::FN_MOVE: begin
							ld = 1'b1;
							if (cmd.ok) begin
								cur_idx_d = cmd.idx;
								cur_row_d = cmd.row;
								cur_col_d = cmd.col;
							end else begin
								sts = tcbuf_pkg::STS_RANGE;
							end
						end
						tcbuf_pkg::FN_PUT: begin
							ld = 1'b1;
							if (cmd.ch == 8'd0) begin
								sts = tcbuf_pkg::STS_NULL;
							end else begin
								mem_we = 1'b1;
							end
						end
						tcbuf_pkg::FN_FWD: begin
							ld        = 1'b1;
							cur_idx_d = fwd_idx;
							cur_row_d = fwd_row;
							cur_col_d = fwd_col;
						end
						tcbuf_pkg::FN_DOWN: begin
							ld = 1'b1;
							if (dn_bell) begin
								sts = tcbuf_pkg::STS_BELL;
							end else begin
								cur_idx_d = dn_idx;
								cur_row_d = cur_row_q + 7'd1;
							end
						end
						tcbuf_pkg::FN_HLINE, tcbuf_pkg::FN_VLINE: begin
							if (!cmd.ok) begin
								ld  = 1'b1;
								sts = tcbuf_pkg::STS_RANGE;
							end else begin
								cur_idx_d = cmd.idx;
								cur_row_d = cmd.row;
								cur_col_d = cmd.col;
								if (cmd.len == 8'd0) begin
									ld = 1'b1;
								end else begin
									line_cnt_d  = cmd.len;
									line_ch_d   = cmd.ch;
									line_vert_d = cmd.func == tcbuf_pkg::FN_VLINE;
									bell_d      = 1'b0;
									state_d     = S_LINE;
								end
							end
						end
						tcbuf_pkg::FN_READ: begin
							if (cmd.ok) begin
								state_d = S_READ;
							end else begin
								ld  = 1'b1;
								sts = tcbuf_pkg::STS_RANGE;
							end
						end
						tcbuf_pkg::FN_CLEAR: begin
							cur_idx_d = '0;
							cur_row_d = 7'd1;
							cur_col_d = 7'd1;
							clr_d     = '0;
							state_d   = S_CLEAR;
						end
						tcbuf_pkg::FN_PUT_ADV: begin
							ld = 1'b1;
							if (cmd.ch == 8'd0) begin
								sts = tcbuf_pkg::STS_NULL;
							end else if (fwd_wrap) begin
								sts = tcbuf_pkg::STS_TRUNC;
							end else begin
								mem_we    = 1'b1;
								cur_idx_d = fwd_idx;
								cur_row_d = fwd_row;
								cur_col_d = fwd_col;
							end
						end
						default: begin
							ld = 1'b1;
						end
					endcase
				end
			end
			S_LINE: begin
				// one cell per cycle: write, then step
				mem_we    = line_ch_q != 8'd0;
				mem_wdata = line_ch_q;
				if (line_vert_q) begin
					if (dn_bell) begin
						bell_now = 1'b1;
					end else begin
						cur_idx_d = dn_idx;
						cur_row_d = cur_row_q + 7'd1;
					end
				end else begin
					cur_idx_d = fwd_idx;
					cur_row_d = fwd_row;
					cur_col_d = fwd_col;
				end
				bell_d     = bell_q | bell_now;
				line_cnt_d = line_cnt_q - 8'd1;
				if (line_cnt_q == 8'd1) begin
					ld      = 1'b1;
					state_d = S_IDLE;
					if (line_ch_q == 8'd0) begin
						sts = tcbuf_pkg::STS_NULL;
					end else if (bell_q | bell_now) begin
						sts = tcbuf_pkg::STS_BELL;
					end
				end
			end
			S_READ: begin
				ld      = 1'b1;
				rd      = mem_rdata;
				state_d = S_IDLE;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = fill;
				clr_d     = clr_q + 1'b1;
				if (clr_last) begin
					ld      = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// geometry change homes the cursor
		if (home) begin
			cur_idx_d = '0;
			cur_row_d = 7'd1;
			cur_col_d = 7'd1;
		end

		// output register
		res_d.status     = sts;
		res_d.read_char  = rd;
		res_d.cursor_row = cur_row_d;
		res_d.cursor_col = cur_col_d;
		if (ld) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			cur_idx_q   <= '0;
			cur_row_q   <= 7'd1;
			cur_col_q   <= 7'd1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			cur_idx_q   <= cur_idx_d;
			cur_row_q   <= cur_row_d;
			cur_col_q   <= cur_col_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Line walker and result payload
	always_ff @(posedge clk) begin
		line_cnt_q  <= line_cnt_d;
		line_ch_q   <= line_ch_d;
		line_vert_q <= line_vert_d;
		bell_q      <= bell_d;
		if (ld) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/text_cell_buffer_with_cursor.sv
// Top level of the character-cell text buffer with cursor.
//
//   channel   direction  handshake            fields
//   in        input      in_valid / in_stall  func, row, col, length, ch
//   out       output     out_valid/out_stall  status, read_char, cursor_row, cursor_col
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// Move, put, forward, down, put_advance and unknown codes finish at dispatch in the
// back end; an in-range read also passes S_READ for the registered read; hline and
// vline are dispatched, then write one cell per cycle; clear sweeps every cell through
// the single write port. Out-of-range commands finish at dispatch.
// An accepted beat goes through the front stage and the queue to the back end.
// After reset the cell memory is swept to the fill character while in_stall stays high;
// in_stall is also high while the geometry settles after each config write.
// The output register lets the back end hand over a result while it is empty or out_stall is low.
module text_cell_buffer_with_cursor #(
	parameter int MAX_CELLS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] func,
	input  logic [6:0] row,
	input  logic [6:0] col,
	input  logic [7:0] length,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] read_char,
	output logic [6:0] cursor_row,
	output logic [6:0] cursor_col,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	tcbuf_pkg::geom_t geom;
	tcbuf_pkg::cmd_t  q_in;
	tcbuf_pkg::cmd_t  q_out;
	tcbuf_pkg::res_t  res;
	logic             geom_busy;
	logic             home;
	logic [7:0]       fill;
	logic             init_busy;
	logic             push;
	logic             pop;
	logic             q_empty;
	logic             q_full;

	tcbuf_geom #(
		.MAX_CELLS (MAX_CELLS)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (geom_busy),
		.home      (home),
		.fill      (fill)
	);

	tcbuf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.row      (row),
		.col      (col),
		.length   (length),
		.ch       (ch),
		.geom     (geom),
		.hold     (geom_busy | init_busy),
		.q_full   (q_full),
		.push     (push),
		.cmd      (q_in)
	);

	tcbuf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_out),
		.empty  (q_empty),
		.full   (q_full)
	);

	tcbuf_back #(
		.MAX_CELLS (MAX_CELLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.home      (home),
		.fill      (fill),
		.cmd       (q_out),
		.q_empty   (q_empty),
		.pop       (pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign status     = res.status;
	assign read_char  = res.read_char;
	assign cursor_row = res.cursor_row;
	assign cursor_col = res.cursor_col;

endmodule

// File: verif/text_cell_buffer_with_cursor_tb.sv
// Testbench for the text cell buffer: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module text_cell_buffer_with_cursor_tb;

	localparam int SCREEN_CELLS = 4096;
	localparam int QUIET_LIMIT  = 40000;
	localparam logic [3:0] FN_SPARE_LO = 4'd9;
	localparam logic [3:0] FN_SPARE_HI = 4'd15;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	// one queued command beat; hold makes the sender wait until all results are back
	typedef struct {
		logic [3:0] func;
		logic [6:0] row;
		logic [6:0] col;
		logic [7:0] len;
		logic [7:0] ch;
		bit         hold;
	} screen_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [3:0] func = '0;
	logic [6:0] row = '0;
	logic [6:0] col = '0;
	logic [7:0] length = '0;
	logic [7:0] ch = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] read_char;
	logic [6:0] cursor_row;
	logic [6:0] cursor_col;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	screen_cmd_t     cmd_backlog[$];
	tcbuf_pkg::res_t due_results[$];
	logic        in_taken = 1'b0;
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	int          n_errors = 0;
	int          n_cmds = 0;
	int          n_checked = 0;
	int          n_clears = 0;
	int          n_ranged = 0;
	int          n_bells = 0;
	int          n_geoms = 0;
	int          quiet = 0;

	// predictor state
	logic [7:0]  screen [SCREEN_CELLS];
	int unsigned cur_idx;
	int unsigned cur_r;
	int unsigned cur_c;
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	logic [7:0]  fill_reg;

	text_cell_buffer_with_cursor #(
		.MAX_CELLS(SCREEN_CELLS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .row(row), .col(col), .length(length), .ch(ch),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .read_char(read_char),
		.cursor_row(cursor_row), .cursor_col(cursor_col),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// geometry actually in use, clamped to 1..64 and to the cell store
	function automatic int unsigned view_cols();
		int unsigned c;
		c = 32'(cols_reg);
		if (c < 1) c = 1;
		if (c > 64) c = 64;
		return c;
	endfunction

	function automatic int unsigned view_rows();
		int unsigned r;
		int unsigned c;
		r = 32'(rows_reg);
		c = view_cols();
		if (r < 1) r = 1;
		if (r > 64) r = 64;
		if (r * c > SCREEN_CELLS) r = SCREEN_CELLS / c;
		if (r < 1) r = 1;
		return r;
	endfunction

	// cursor placement; anything past the last cell lands on home
	function automatic void seat_cursor(int unsigned idx);
		int unsigned c;
		c = view_cols();
		if (idx >= view_rows() * c) idx = 0;
		cur_idx = idx;
		cur_r = idx / c + 1;
		cur_c = idx % c + 1;
	endfunction

	function automatic bit on_screen(int unsigned r, int unsigned c);
		return r >= 1 && r <= view_rows() && c >= 1 && c <= view_cols();
	endfunction

	function automatic void poke(logic [7:0] v);
		if (v != 8'd0 && cur_idx < SCREEN_CELLS) screen[cur_idx] = v;
	endfunction

	// returns 1 when already on the bottom row
	function automatic bit cursor_down();
		if (cur_r >= view_rows()) return 1'b1;
		seat_cursor(cur_idx + view_cols());
		return 1'b0;
	endfunction

	function automatic void wipe_screen(logic [7:0] v);
		for (int i = 0; i < SCREEN_CELLS; i++) screen[i] = v;
	endfunction

	// applies one command to the screen and cursor, returns the result beat
	function automatic tcbuf_pkg::res_t screen_apply(logic [3:0] f, logic [6:0] r,
			logic [6:0] c, logic [7:0] n, logic [7:0] v);
		tcbuf_pkg::res_t res;
		bit          bell;
		int unsigned ri;
		int unsigned ci;
		int unsigned idx;
		res = '0;
		bell = 1'b0;
		ri = 32'(r);
		ci = 32'(c);
		case (f)
		tcbuf_pkg::FN_MOVE: begin
			if (on_screen(ri, ci)) seat_cursor((ri - 1) * view_cols() + (ci - 1));
			else res.status = tcbuf_pkg::STS_RANGE;
		end
		tcbuf_pkg::FN_PUT: begin
			if (v == 8'd0) res.status = tcbuf_pkg::STS_NULL;
			else poke(v);
		end
		tcbuf_pkg::FN_FWD: seat_cursor(cur_idx + 1);
		tcbuf_pkg::FN_DOWN: begin
			if (cursor_down()) res.status = tcbuf_pkg::STS_BELL;
		end
		tcbuf_pkg::FN_HLINE, tcbuf_pkg::FN_VLINE: begin
			if (!on_screen(ri, ci)) begin
				res.status = tcbuf_pkg::STS_RANGE;
			end else begin
				seat_cursor((ri - 1) * view_cols() + (ci - 1));
				for (int i = 0; i < int'(n); i++) begin
					poke(v);
					if (f == tcbuf_pkg::FN_HLINE) seat_cursor(cur_idx + 1);
					else if (cursor_down()) bell = 1'b1;
				end
				if (v == 8'd0 && n != 8'd0) res.status = tcbuf_pkg::STS_NULL;
				else if (bell) res.status = tcbuf_pkg::STS_BELL;
			end
		end
		tcbuf_pkg::FN_READ: begin
			if (on_screen(ri, ci)) begin
				idx = (ri - 1) * view_cols() + (ci - 1);
				if (idx < SCREEN_CELLS) res.read_char = screen[idx];
			end else begin
				res.status = tcbuf_pkg::STS_RANGE;
			end
		end
		tcbuf_pkg::FN_CLEAR: begin
			wipe_screen(fill_reg);
			seat_cursor(0);
		end
		tcbuf_pkg::FN_PUT_ADV: begin
			if (v == 8'd0) begin
				res.status = tcbuf_pkg::STS_NULL;
			end else if (cur_idx + 1 >= view_rows() * view_cols()) begin
				res.status = tcbuf_pkg::STS_TRUNC;
			end else begin
				poke(v);
				seat_cursor(cur_idx + 1);
			end
		end
		default: ;
		endcase
		res.cursor_row = cur_r[6:0];
		res.cursor_col = cur_c[6:0];
		return res;
	endfunction

	// mostly in range, sometimes zero, the top code or a value past the edge
	function automatic logic [6:0] pick_coord(int unsigned span);
		logic [6:0] p;
		if ($urandom_range(0, 9) != 0) p = 7'($urandom_range(1, span));
		else case ($urandom_range(0, 2))
			0: p = 7'd0;
			1: p = 7'd127;
			default: p = 7'($urandom_range(span + 1, 127));
		endcase
		return p;
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch @%0t: %s", $time, what);
		n_errors++;
	endtask

	task automatic add_cmd(logic [3:0] f, logic [6:0] r, logic [6:0] c, logic [7:0] n,
			logic [7:0] v, bit hold);
		screen_cmd_t item;
		item.func = f;
		item.row = r;
		item.col = c;
		item.len = n;
		item.ch = v;
		item.hold = hold;
		cmd_backlog.push_back(item);
	endtask

	// wakes between edges so no update of this time step is pending
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#0.5;
		end while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0);
	endtask

	// register write while idle; mirrors the effect in the predictor
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		while (in_stall) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		tcbuf_pkg::CFG_ROWS: begin
			rows_reg = val[6:0];
			seat_cursor(0);
		end
		tcbuf_pkg::CFG_COLS: begin
			cols_reg = val[6:0];
			seat_cursor(0);
		end
		tcbuf_pkg::CFG_FILL: fill_reg = val;
		default: ;
		endcase
	endtask

	// command sender: holds a stalled beat, otherwise takes the next one or idles
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (cmd_backlog.size() != 0 && !(cmd_backlog[0].hold && due_results.size() != 0)
					&& $urandom_range(0, 99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				func <= cmd_backlog[0].func;
				row <= cmd_backlog[0].row;
				col <= cmd_backlog[0].col;
				length <= cmd_backlog[0].len;
				ch <= cmd_backlog[0].ch;
				void'(cmd_backlog.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver back-pressure
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < stall_pct);
	end

	// predict on accepted commands, check result beats, watch for a hang
	always @(posedge clk) begin
		tcbuf_pkg::res_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result beat with nothing pending");
				end else begin
					want = due_results.pop_front();
					n_checked++;
					if (status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d", status, want.status));
					if (read_char !== want.read_char)
						flag_mismatch($sformatf("read_char %0h, want %0h",
							read_char, want.read_char));
					if (cursor_row !== want.cursor_row)
						flag_mismatch($sformatf("cursor_row %0d, want %0d",
							cursor_row, want.cursor_row));
					if (cursor_col !== want.cursor_col)
						flag_mismatch($sformatf("cursor_col %0d, want %0d",
							cursor_col, want.cursor_col));
				end
			end
			if (in_valid && !in_stall) begin
				want = screen_apply(func, row, col, length, ch);
				due_results.push_back(want);
				n_cmds++;
				if (func == tcbuf_pkg::FN_CLEAR) n_clears++;
				if (want.status == tcbuf_pkg::STS_RANGE) n_ranged++;
				if (want.status == tcbuf_pkg::STS_BELL) n_bells++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					quiet, due_results.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int          pick;
		int          lsel;
		logic [3:0]  f;
		logic [6:0]  r;
		logic [6:0]  c;
		logic [7:0]  n;
		logic [7:0]  v;
		logic [7:0]  g_rows;
		logic [7:0]  g_cols;
		logic [7:0]  g_fill;

		// predictor matches the post-reset sweep
		rows_reg = 7'd8;
		cols_reg = 7'd40;
		fill_reg = tcbuf_pkg::RESET_FILL;
		wipe_screen(tcbuf_pkg::RESET_FILL);
		seat_cursor(0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pass on the reset geometry, 8 x 40
		send_gap_pct = 30;
		stall_pct = 47;
		add_cmd(tcbuf_pkg::FN_READ, 7'd1, 7'd1, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd8, 7'd40, 8'd0, 8'd0, 1'b0);
		// dropped on the last cell
		add_cmd(tcbuf_pkg::FN_PUT_ADV, 7'd0, 7'd0, 8'd0, 8'h41, 1'b0);
		add_cmd(tcbuf_pkg::FN_PUT, 7'd0, 7'd0, 8'd0, 8'h5A, 1'b0);
		add_cmd(tcbuf_pkg::FN_FWD, 7'd0, 7'd0, 8'd0, 8'd0, 1'b0);        // wraps home
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd8, 7'd5, 8'd0, 8'd0, 1'b0);
		// bell on the bottom row
		add_cmd(tcbuf_pkg::FN_DOWN, 7'd0, 7'd0, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd0, 7'd0, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd9, 7'd1, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd1, 7'd41, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_MOVE, 7'd127, 7'd127, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_PUT, 7'd0, 7'd0, 8'd0, 8'd0, 1'b0);        // NUL ignored
		add_cmd(tcbuf_pkg::FN_PUT_ADV, 7'd0, 7'd0, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_PUT_ADV, 7'd0, 7'd0, 8'd0, 8'hFF, 1'b0);
		// runs past the end, wraps
		add_cmd(tcbuf_pkg::FN_HLINE, 7'd8, 7'd30, 8'd255, 8'h80, 1'b0);
		// bottom cell rewritten, bell
		add_cmd(tcbuf_pkg::FN_VLINE, 7'd6, 7'd3, 8'd5, 8'h56, 1'b0);
		// NUL run, cursor still walks
		add_cmd(tcbuf_pkg::FN_HLINE, 7'd1, 7'd1, 8'd4, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_VLINE, 7'd2, 7'd2, 8'd0, 8'h78, 1'b0);
		add_cmd(tcbuf_pkg::FN_HLINE, 7'd9, 7'd1, 8'd3, 8'h2D, 1'b0);
		add_cmd(tcbuf_pkg::FN_READ, 7'd8, 7'd40, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_READ, 7'd1, 7'd41, 8'd0, 8'd0, 1'b0);
		add_cmd(tcbuf_pkg::FN_READ, 7'd127, 7'd0, 8'd0, 8'd0, 1'b0);
		add_cmd(FN_SPARE_LO, 7'd127, 7'd127, 8'd255, 8'd255, 1'b0);
		add_cmd(FN_SPARE_HI, 7'd5, 7'd5, 8'd1, 8'd1, 1'b0);
		// sender waits for a drain first
		add_cmd(tcbuf_pkg::FN_CLEAR, 7'd0, 7'd0, 8'd0, 8'd0, 1'b1);
		add_cmd(tcbuf_pkg::FN_READ, 7'd8, 7'd40, 8'd0, 8'd0, 1'b0);
		n_geoms = 1;
		wait_drained();

		// random passes, each under its own geometry and fill
		for (int ph = 0; ph < 7; ph++) begin
			if (ph < 2) begin
				send_gap_pct = 30;
				stall_pct = 47;
			end else if (ph < 5) begin
				send_gap_pct = 47;
				stall_pct = 30;
			end else begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
			case (ph)
			0: begin g_rows = 8'd1;   g_cols = 8'd1;   g_fill = 8'h00; end
			1: begin g_rows = 8'd64;  g_cols = 8'd64;  g_fill = 8'hFF; end
			2: begin g_rows = 8'd0;   g_cols = 8'd0;   g_fill = 8'h55; end
			3: begin g_rows = 8'hFF;  g_cols = 8'd100; g_fill = 8'hAA; end
			4: begin g_rows = 8'd3;   g_cols = 8'd5;   g_fill = 8'h2E; end
			5: begin g_rows = 8'd64;  g_cols = 8'd1;   g_fill = 8'($urandom_range(1, 255)); end
			default: begin g_rows = 8'd8; g_cols = 8'd40; g_fill = tcbuf_pkg::RESET_FILL; end
			endcase
			write_reg(tcbuf_pkg::CFG_ROWS, g_rows);
			write_reg(tcbuf_pkg::CFG_COLS, g_cols);
			write_reg(tcbuf_pkg::CFG_FILL, g_fill);
			if (ph == 6) write_reg(CFG_UNUSED, 8'h3C);
			n_geoms++;

			for (int k = 0; k < 86; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) f = tcbuf_pkg::FN_MOVE;
				else if (pick < 24) f = tcbuf_pkg::FN_PUT;
				else if (pick < 32) f = tcbuf_pkg::FN_FWD;
				else if (pick < 40) f = tcbuf_pkg::FN_DOWN;
				else if (pick < 52) f = tcbuf_pkg::FN_HLINE;
				else if (pick < 62) f = tcbuf_pkg::FN_VLINE;
				else if (pick < 76) f = tcbuf_pkg::FN_READ;
				else if (pick < 78) f = tcbuf_pkg::FN_CLEAR;
				else if (pick < 96) f = tcbuf_pkg::FN_PUT_ADV;
				else f = 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
				r = pick_coord(view_rows());
				c = pick_coord(view_cols());
				// short runs dominate, a few long ones
				lsel = $urandom_range(0, 19);
				if (lsel < 14) n = 8'($urandom_range(0, 8));
				else if (lsel < 19) n = 8'($urandom_range(9, 70));
				else n = 8'($urandom_range(71, 255));
				v = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
				add_cmd(f, r, c, n, v, $urandom_range(0, 49) == 0);
			end
			wait_drained();
		end

		// let any stray beat show up
		repeat (40) @(posedge clk);
		$display("covered %0d commands, %0d results checked, over %0d screen geometries",
			n_cmds, n_checked, n_geoms);
		$display("including %0d clears, %0d out-of-range and %0d bell results",
			n_clears, n_ranged, n_bells);
		if (n_errors == 0 && due_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/tcbuf_pkg.sv
rtl/tcbuf_ram.sv
rtl/tcbuf_geom.sv
rtl/tcbuf_front.sv
rtl/tcbuf_fifo.sv
rtl/tcbuf_back.sv
rtl/text_cell_buffer_with_cursor.sv
verif/text_cell_buffer_with_cursor_tb.sv
